/* rtl/core/hwps_pkg.sv */
package hwps_pkg;

  // Pipeline depth: two prep stages, one stage per quotient bit, one classify stage
  localparam int DIV_STEPS = 8;
  localparam int STG_N     = DIV_STEPS + 3;

  // Register indexes of the configuration port
  localparam logic [7:0] REG_HUE_UPPER = 8'd0;
  localparam logic [7:0] REG_HUE_LOWER = 8'd1;
  localparam logic [7:0] REG_SAT_UPPER = 8'd2;
  localparam logic [7:0] REG_SAT_LOWER = 8'd3;

  localparam logic [7:0] RST_HUE_UPPER = 8'd179;
  localparam logic [7:0] RST_HUE_LOWER = 8'd0;
  localparam logic [7:0] RST_SAT_UPPER = 8'd255;
  localparam logic [7:0] RST_SAT_LOWER = 8'd0;

  // Half-degree hue wraps at this value
  localparam logic [7:0] HUE_WRAP = 8'd180;
  localparam logic [7:0] HUE_MAX  = 8'd179;

  // Which channel holds the maximum; red wins ties, then green
  typedef enum logic [1:0] {
    SEL_R,
    SEL_G,
    SEL_B
  } hwps_sel_t;

  typedef struct packed {
    logic [7:0] hue_upper;
    logic [7:0] hue_lower;
    logic [7:0] sat_upper;
    logic [7:0] sat_lower;
  } hwps_cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hwps_pix_t;

  // First prep stage: extremes of the pixel
  typedef struct packed {
    hwps_pix_t  pix;
    logic [7:0] vmax;
    logic [7:0] diff;
    hwps_sel_t  sel;
  } hwps_ext_t;

  // Restoring division state: remainder, shifted divisor, quotient so far
  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] dsh;
    logic [7:0]  quo;
  } hwps_div_t;

  // Data carried through the divider stages
  typedef struct packed {
    hwps_pix_t pix;
    logic      gray;
    logic      black;
    logic      rcase;
    hwps_div_t hdiv;
    hwps_div_t sdiv;
  } hwps_stg_t;

  typedef struct packed {
    logic       in_range;
    hwps_pix_t  pix;
    logic [7:0] hue;
    logic [7:0] sat;
  } hwps_res_t;

endpackage

/* rtl/core/hwps_prep.sv */
module hwps_prep
  import hwps_pkg::*;
(
  input  logic      clk,
  input  logic      en_a,
  input  logic      en_b,
  input  hwps_pix_t pix_in,
  output hwps_stg_t stg_out
);

  hwps_ext_t ext_r, ext_nxt;
  hwps_stg_t stg_r, stg_nxt;

  logic [7:0] vmin;

  // Find the maximum channel, the minimum and their spread
  always_comb begin
    ext_nxt.pix = pix_in;
    if (pix_in.red >= pix_in.green && pix_in.red >= pix_in.blue) begin
      ext_nxt.sel  = SEL_R;
      ext_nxt.vmax = pix_in.red;
    end else if (pix_in.green >= pix_in.blue) begin
      ext_nxt.sel  = SEL_G;
      ext_nxt.vmax = pix_in.green;
    end else begin
      ext_nxt.sel  = SEL_B;
      ext_nxt.vmax = pix_in.blue;
    end
    if (pix_in.red <= pix_in.green && pix_in.red <= pix_in.blue) begin
      vmin = pix_in.red;
    end else if (pix_in.green <= pix_in.blue) begin
      vmin = pix_in.green;
    end else begin
      vmin = pix_in.blue;
    end
    ext_nxt.diff = ext_nxt.vmax - vmin;
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ext_r <= ext_nxt;
    end
  end

  logic signed [9:0]  dsel;
  logic        [9:0]  kcoef;
  logic signed [19:0] hnum;
  logic        [16:0] snum;

  // Build the dividends; the red case is offset by a full turn to stay positive
  always_comb begin
    unique case (ext_r.sel)
      SEL_R: begin
        dsel  = $signed({2'b00, ext_r.pix.green}) - $signed({2'b00, ext_r.pix.blue});
        kcoef = 10'd361;
      end
      SEL_G: begin
        dsel  = $signed({2'b00, ext_r.pix.blue}) - $signed({2'b00, ext_r.pix.red});
        kcoef = 10'd121;
      end
      SEL_B: begin
        dsel  = $signed({2'b00, ext_r.pix.red}) - $signed({2'b00, ext_r.pix.green});
        kcoef = 10'd241;
      end
      default: begin
        dsel  = 10'sd0;
        kcoef = 10'd0;
      end
    endcase
    hnum = $signed({12'd0, ext_r.diff}) * $signed({10'd0, kcoef})
         + $signed(20'sd60) * $signed({{10{dsel[9]}}, dsel});
    snum = 17'(ext_r.diff) * 17'd510 + 17'(ext_r.vmax);

    stg_nxt.pix      = ext_r.pix;
    stg_nxt.gray     = (ext_r.diff == 8'd0);
    stg_nxt.black    = (ext_r.vmax == 8'd0);
    stg_nxt.rcase    = (ext_r.sel == SEL_R);
    stg_nxt.hdiv.rem = hnum[16:0];
    stg_nxt.hdiv.dsh = {ext_r.diff, 8'd0};
    stg_nxt.hdiv.quo = 8'd0;
    stg_nxt.sdiv.rem = snum;
    stg_nxt.sdiv.dsh = {ext_r.vmax, 8'd0};
    stg_nxt.sdiv.quo = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_out = stg_r;

endmodule

/* rtl/core/hwps_div_step.sv */
module hwps_div_step
  import hwps_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  hwps_stg_t stg_in,
  output hwps_stg_t stg_out
);

  hwps_stg_t stg_r, stg_nxt;

  function automatic hwps_div_t div_bit(hwps_div_t d);
    hwps_div_t o;
    logic      take;
    take  = (d.rem >= {1'b0, d.dsh});
    o.rem = take ? (d.rem - {1'b0, d.dsh}) : d.rem;
    o.dsh = {1'b0, d.dsh[15:1]};
    o.quo = {d.quo[6:0], take};
    return o;
  endfunction

  // Resolve one quotient bit of hue and of saturation
  always_comb begin
    stg_nxt      = stg_in;
    stg_nxt.hdiv = div_bit(stg_in.hdiv);
    stg_nxt.sdiv = div_bit(stg_in.sdiv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_out = stg_r;

endmodule

/* rtl/core/hwps_classify.sv */
module hwps_classify
  import hwps_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  hwps_cfg_t cfg,
  input  hwps_stg_t stg_in,
  output hwps_res_t res_out
);

  hwps_res_t res_r, res_nxt;

  logic hue_ok;
  logic sat_ok;
  logic keep;

  // Fold the hue back into one turn, then test both windows
  always_comb begin
    if (stg_in.gray) begin
      res_nxt.hue = 8'd0;
    end else if (stg_in.rcase && stg_in.hdiv.quo >= HUE_WRAP) begin
      res_nxt.hue = stg_in.hdiv.quo - HUE_WRAP;
    end else begin
      res_nxt.hue = stg_in.hdiv.quo;
    end
    res_nxt.sat = stg_in.black ? 8'd0 : stg_in.sdiv.quo;

    if (cfg.hue_upper < cfg.hue_lower) begin
      hue_ok = (res_nxt.hue <= cfg.hue_upper) || (res_nxt.hue >= cfg.hue_lower);
    end else begin
      hue_ok = (res_nxt.hue <= cfg.hue_upper) && (res_nxt.hue >= cfg.hue_lower);
    end
    sat_ok = (res_nxt.sat <= cfg.sat_upper) && (res_nxt.sat >= cfg.sat_lower);
    keep   = hue_ok && sat_ok;

    res_nxt.in_range = keep;
    res_nxt.pix      = keep ? stg_in.pix : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_out = res_r;

endmodule

/* rtl/core/hsv_window_pixel_segmenter.sv */
// Channel  Direction  Handshake                  Payload
// in_      slave      in_tvalid / in_tready      red, green, blue
// out_     master     out_tvalid / out_tready    tdata: colors, hue, sat; tuser: in_range
// cfg_     slave      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One pixel per clock while out_tready is high; each request passes through two prep stages,
// eight restoring-divider stages at one quotient bit each and one classify stage to the output register.
// Each stage advances when it is empty or the next one advances, so bubbles collapse
// and a stall on out_tready holds every request in place.
// rst_n clears the stage valid bits and loads the window registers with their defaults.
// cfg_ready is always high; writes to an index above 3 are dropped.
module hsv_window_pixel_segmenter
  import hwps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16],
                                  // hue[31:24], saturation[39:32]
  output logic        out_tuser,  // in_range[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  hwps_cfg_t cfg_r, cfg_nxt;

  // Take window writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HUE_UPPER: cfg_nxt.hue_upper = cfg_data;
        REG_HUE_LOWER: cfg_nxt.hue_lower = cfg_data;
        REG_SAT_UPPER: cfg_nxt.sat_upper = cfg_data;
        REG_SAT_LOWER: cfg_nxt.sat_lower = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_upper <= RST_HUE_UPPER;
      cfg_r.hue_lower <= RST_HUE_LOWER;
      cfg_r.sat_upper <= RST_SAT_UPPER;
      cfg_r.sat_lower <= RST_SAT_LOWER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // Stage valid bits and advance enables
  logic [STG_N-1:0] vld_r, vld_nxt;
  logic [STG_N:0]   adv;

  always_comb begin
    adv[STG_N] = out_tready;
    for (int k = STG_N - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    for (int k = 0; k < STG_N; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = adv[0];

  // Datapath
  hwps_pix_t pix_in;
  hwps_stg_t stg [DIV_STEPS+1];
  hwps_res_t res;

  assign pix_in.red   = in_tdata[7:0];
  assign pix_in.green = in_tdata[15:8];
  assign pix_in.blue  = in_tdata[23:16];

  hwps_prep u_prep (
    .clk     (clk),
    .en_a    (adv[0]),
    .en_b    (adv[1]),
    .pix_in  (pix_in),
    .stg_out (stg[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    hwps_div_step u_step (
      .clk     (clk),
      .en      (adv[i+2]),
      .stg_in  (stg[i]),
      .stg_out (stg[i+1])
    );
  end

  hwps_classify u_classify (
    .clk     (clk),
    .en      (adv[STG_N-1]),
    .cfg     (cfg_r),
    .stg_in  (stg[DIV_STEPS]),
    .res_out (res)
  );

  assign out_tvalid = vld_r[STG_N-1];
  assign out_tdata  = {res.sat, res.hue, res.pix.blue, res.pix.green, res.pix.red};
  assign out_tuser  = res.in_range;

endmodule

/* rtl/core/hwps_checker.sv */
module hwps_checker
  import hwps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An empty output stage leaves the whole pipe free to take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Rejected pixels are zeroed
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:0] == 24'd0)
    else $error("rejected pixel not zeroed");

  // Hue stays within one turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:24] <= HUE_MAX)
    else $error("hue out of range");

endmodule

bind hsv_window_pixel_segmenter hwps_checker u_hwps_checker (.*);
